FILE: sv/crm_pkg.sv
// Package for the clamped range map: widths, easing codes, register indexes.
// No dependencies.
package crm_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [1:0] {
    EaseLinear = 2'd0,
    EaseIn     = 2'd1,
    EaseOut    = 2'd2,
    EaseInOut  = 2'd3
  } ease_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegInStart  = 2'd0,
    RegInEnd    = 2'd1,
    RegOutStart = 2'd2,
    RegOutEnd   = 2'd3
  } cfg_idx_e;
endpackage

FILE: sv/crm_div_cell.sv
// One restoring-division cell: produces one quotient bit per pipeline stage.
// Depends on crm_pkg.
module crm_div_cell #(
  parameter int unsigned DW = crm_pkg::DataWidth,
  parameter int unsigned FW = crm_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic          en_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW:0]   den_i,
  input  logic [FW:0]   quo_i,
  input  logic [1:0]    mode_i,
  input  logic          empty_i,
  input  logic          sat_i,
  output logic          valid_o,
  output logic [DW:0]   rem_o,
  output logic [DW:0]   den_o,
  output logic [FW:0]   quo_o,
  output logic [1:0]    mode_o,
  output logic          empty_o,
  output logic          sat_o
);
  import crm_pkg::*;

  logic [DW+1:0] sh;
  logic          ge;
  logic          valid_q;
  logic [DW:0]   rem_q, den_q;
  logic [FW:0]   quo_q;
  logic [1:0]    mode_q;
  logic          empty_q, sat_q;

  // shift-compare-subtract step
  assign sh = {rem_i, 1'b0};
  assign ge = (sh >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= ge ? (DW+1)'(sh - {1'b0, den_i}) : sh[DW:0];
      den_q   <= den_i;
      quo_q   <= {quo_i[FW-1:0], ge};
      mode_q  <= mode_i;
      empty_q <= empty_i;
      sat_q   <= sat_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign mode_o  = mode_q;
  assign empty_o = empty_q;
  assign sat_o   = sat_q;
endmodule

FILE: sv/clamped_range_map_with_easing_top.sv
// Top level of the clamped range map with easing: config regs, front end,
// chain of division cells, easing and scaling stages. Depends on crm_pkg, crm_div_cell.
// Path: front-end register, chain of division cells, stages E1, E2, E3 and M, output register.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is empty or being taken, set by the single output stage.
// Reset: config regs return to 0/9999/0/9999, all valid bits clear.
module clamped_range_map_with_easing_top #(
  parameter int unsigned DATA_WIDTH = crm_pkg::DataWidth,
  parameter int unsigned FRAC_BITS  = crm_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] in_value_i,
  input  logic [1:0]                   mode_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] out_value_o,
  output logic                         range_empty_o
);
  import crm_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned FW = FRAC_BITS;
  localparam logic [FW:0] One = (FW+1)'(1) << FW;

  logic signed [DW-1:0] in_start_q, in_end_q, out_start_q, out_end_q;
  logic en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_start_q  <= '0;
      in_end_q    <= DW'(9999);
      out_start_q <= '0;
      out_end_q   <= DW'(9999);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegInStart:  in_start_q  <= cfg_data_i;
        RegInEnd:    in_end_q    <= cfg_data_i;
        RegOutStart: out_start_q <= cfg_data_i;
        RegOutEnd:   out_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipe moves together; output reg frees when taken
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // front end: numerator/denominator magnitudes and special cases
  logic signed [DW:0] num, den;
  logic [DW:0] an, ad;
  logic zero_t, sat_t, empty;
  assign num   = (DW+1)'(in_value_i) - (DW+1)'(in_start_q);
  assign den   = (DW+1)'(in_end_q) - (DW+1)'(in_start_q);
  assign an    = num[DW] ? (DW+1)'(-num) : num;
  assign ad    = den[DW] ? (DW+1)'(-den) : den;
  assign empty = (den == '0);
  assign zero_t = (num == '0) || (num[DW] != den[DW]);
  assign sat_t  = !zero_t && (an >= ad);

  logic          f_valid_q, f_empty_q, f_sat_q;
  logic [DW:0]   f_rem_q, f_den_q;
  logic [1:0]    f_mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_rem_q   <= (zero_t || sat_t || empty) ? '0 : an;
      f_den_q   <= empty ? (DW+1)'(1) : ad;
      f_mode_q  <= mode_i;
      f_empty_q <= empty;
      f_sat_q   <= sat_t;
    end
  end

  // chain of division cells
  logic [FW:0] c_valid, c_empty, c_sat;
  logic [DW:0] c_rem [FW+1];
  logic [DW:0] c_den [FW+1];
  logic [FW:0] c_quo [FW+1];
  logic [1:0]  c_mode [FW+1];
  assign c_valid[0] = f_valid_q;
  assign c_rem[0]   = f_rem_q;
  assign c_den[0]   = f_den_q;
  assign c_quo[0]   = '0;
  assign c_mode[0]  = f_mode_q;
  assign c_empty[0] = f_empty_q;
  assign c_sat[0]   = f_sat_q;

  for (genvar g = 0; g < FW; g++) begin : g_div
    crm_div_cell #(.DW(DW), .FW(FW)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(c_valid[g]), .en_i(en),
      .rem_i(c_rem[g]), .den_i(c_den[g]), .quo_i(c_quo[g]),
      .mode_i(c_mode[g]), .empty_i(c_empty[g]), .sat_i(c_sat[g]),
      .valid_o(c_valid[g+1]), .rem_o(c_rem[g+1]), .den_o(c_den[g+1]),
      .quo_o(c_quo[g+1]), .mode_o(c_mode[g+1]), .empty_o(c_empty[g+1]),
      .sat_o(c_sat[g+1])
    );
  end

  // stage E1: t and first square
  logic [FW:0] t_w, sq_in;
  assign t_w   = c_sat[FW] ? One : c_quo[FW];
  assign sq_in = (ease_e'(c_mode[FW]) == EaseOut) ? One - t_w : t_w;

  logic          e1_valid_q, e1_empty_q;
  logic [FW:0]   e1_t_q;
  logic [2*FW+1:0] e1_sq_q;
  logic [1:0]    e1_mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e1_valid_q <= 1'b0;
    else if (en) e1_valid_q <= c_valid[FW];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_t_q     <= t_w;
      e1_sq_q    <= sq_in * sq_in;
      e1_mode_q  <= c_mode[FW];
      e1_empty_q <= c_empty[FW];
    end
  end

  // stage E2: cube for in-out
  logic [FW:0] t2;
  assign t2 = e1_sq_q[2*FW:FW];
  logic          e2_valid_q, e2_empty_q;
  logic [FW:0]   e2_t_q, e2_t2_q;
  logic [2*FW+1:0] e2_cu_q;
  logic [1:0]    e2_mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e2_valid_q <= 1'b0;
    else if (en) e2_valid_q <= e1_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_t_q     <= e1_t_q;
      e2_t2_q    <= t2;
      e2_cu_q    <= t2 * e1_t_q;
      e2_mode_q  <= e1_mode_q;
      e2_empty_q <= e1_empty_q;
    end
  end

  // stage E3: select eased fraction
  logic [FW:0]   t3;
  logic [FW+2:0] io;
  logic [FW:0]   e_w;
  assign t3 = e2_cu_q[2*FW:FW];
  assign io = (FW+3)'(3) * (FW+3)'(e2_t2_q) - (FW+3)'(2) * (FW+3)'(t3);
  always_comb begin
    case (ease_e'(e2_mode_q))
      EaseIn:    e_w = e2_t2_q;
      EaseOut:   e_w = One - e2_t2_q;
      EaseInOut: e_w = (io > (FW+3)'(One)) ? One : io[FW:0];
      default:   e_w = e2_t_q;
    endcase
  end

  logic        e3_valid_q, e3_empty_q;
  logic [FW:0] e3_e_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e3_valid_q <= 1'b0;
    else if (en) e3_valid_q <= e2_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_e_q     <= e_w;
      e3_empty_q <= e2_empty_q;
    end
  end

  // stage M: span magnitude times eased fraction
  logic signed [DW:0] span;
  logic [DW:0] am;
  assign span = (DW+1)'(out_end_q) - (DW+1)'(out_start_q);
  assign am   = span[DW] ? (DW+1)'(-span) : span;

  logic              m_valid_q, m_empty_q, m_neg_q;
  logic [DW+FW+1:0]  m_prod_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (en) m_valid_q <= e3_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q  <= am * e3_e_q;
      m_neg_q   <= span[DW];
      m_empty_q <= e3_empty_q;
    end
  end

  // stage S: add, truncate toward zero, clamp; an empty range gives out_start
  logic [DW:0] q;
  logic        rnz;
  logic signed [DW+1:0] s, lo_b, hi_b, sc;
  assign q   = m_prod_q[DW+FW:FW];
  assign rnz = (m_prod_q[FW-1:0] != '0);
  always_comb begin
    if (!m_neg_q) s = (DW+2)'(out_start_q) + (DW+2)'(q);
    else s = (DW+2)'(out_start_q) - (DW+2)'(q) - (DW+2)'(rnz);
    if (rnz && s < 0) s = s + (DW+2)'(1);
    lo_b = (out_start_q < out_end_q) ? (DW+2)'(out_start_q) : (DW+2)'(out_end_q);
    hi_b = (out_start_q < out_end_q) ? (DW+2)'(out_end_q) : (DW+2)'(out_start_q);
    sc = s;
    if (sc < lo_b) sc = lo_b;
    if (sc > hi_b) sc = hi_b;
    if (m_empty_q) sc = (DW+2)'(out_start_q);
  end

  // output register
  logic                 o_valid_q, o_empty_q;
  logic signed [DW-1:0] o_value_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_valid_q <= 1'b0;
    else if (en) o_valid_q <= m_valid_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      o_value_q <= sc[DW-1:0];
      o_empty_q <= m_empty_q;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign out_value_o   = o_value_q;
  assign range_empty_o = o_empty_q;

  // a stalled output keeps the pipe frozen
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(m_prod_q) && out_valid_o)
    else $error("pipe advanced under stall");
  // eased fraction never exceeds one
  a_ease_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e3_valid_q |-> (e3_e_q <= One))
    else $error("eased fraction out of range");
  // an empty range forces out_start
  a_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_empty_q && en) |=> (out_value_o == $past(out_start_q)))
    else $error("empty range value wrong");
endmodule

FILE: bench/tb_clamped_range_map_with_easing_top.sv
// Self-checking bench for clamped_range_map_with_easing_top: predicts each mapped value
// and empty-range flag, with random burst gaps on input and random stalls on output.
// Depends on crm_pkg and the block's RTL.
module tb_clamped_range_map_with_easing_top;
  import crm_pkg::*;

  localparam int unsigned DW = DataWidth;
  localparam int unsigned FB = FracBits;
  localparam longint unsigned OneQ = 64'd1 << FB;
  localparam int Latency = FB + 6;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic signed [DW-1:0] value;
    ease_e                mode;
  } sample_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 empty;
  } mapped_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [DW-1:0]        cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [DW-1:0] in_value_i = '0;
  logic [1:0]           mode_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [DW-1:0] out_value_o;
  logic                 range_empty_o;

  clamped_range_map_with_easing_top DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bench copy of the range registers.
  longint range_in_lo, range_in_hi, range_out_lo, range_out_hi;

  sample_t pending_samples[$];
  mapped_t expected_maps[$];
  int      mismatches = 0;
  longint  cycles = 0;
  bit      feed_on = 1'b0;

  function automatic longint unsigned ease_frac(longint unsigned t, ease_e m);
    longint unsigned t2, t3, u, e;
    case (m)
      EaseIn: ease_frac = (t * t) >> FB;
      EaseOut: begin
        u = OneQ - t;
        ease_frac = OneQ - ((u * u) >> FB);
      end
      EaseInOut: begin
        t2 = (t * t) >> FB;
        t3 = (t2 * t) >> FB;
        e = 3 * t2 - 2 * t3;
        ease_frac = (e > OneQ) ? OneQ : e;
      end
      default: ease_frac = t;
    endcase
  endfunction

  function automatic mapped_t map_sample(sample_t s);
    longint num, den, span, res, lo_b, hi_b;
    longint unsigned an, ad, t, e, am, plo, q, r;
    mapped_t m;
    num = longint'(s.value) - range_in_lo;
    den = range_in_hi - range_in_lo;
    if (den == 0) begin
      m.value = range_out_lo[DW-1:0];
      m.empty = 1'b1;
      return m;
    end
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (num == 0 || ((num < 0) != (den < 0))) t = 0;
    else if (an >= ad) t = OneQ;
    else t = (an << FB) / ad;  // an < 2^33, fits
    e = ease_frac(t, s.mode);
    span = range_out_hi - range_out_lo;
    am = (span < 0) ? -span : span;
    // span < 2^33 and e <= 2^16: product fits in 64 bits
    plo = am * e;
    q = plo >> FB;
    r = plo & (OneQ - 1);
    if (span >= 0) res = range_out_lo + longint'(q);
    else res = range_out_lo - longint'(q) - ((r != 0) ? 1 : 0);
    if (r != 0 && res < 0) res += 1;
    lo_b = (range_out_lo < range_out_hi) ? range_out_lo : range_out_hi;
    hi_b = (range_out_lo < range_out_hi) ? range_out_hi : range_out_lo;
    if (res < lo_b) res = lo_b;
    if (res > hi_b) res = hi_b;
    m.value = res[DW-1:0];
    m.empty = 1'b0;
    return m;
  endfunction

  // Driver: bursts of beats with random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_maps.push_back(map_sample(pending_samples.pop_front()));
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (feed_on && pending_samples.size() > 0) begin
          in_valid_i <= 1'b1;
          in_value_i <= pending_samples[0].value;
          mode_i <= pending_samples[0].mode;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls: alternating ready and stall runs.
  int stall_run = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_run > 0) begin
        stall_run <= stall_run - 1;
      end else begin
        out_ready_i <= !out_ready_i;
        stall_run <= out_ready_i ? $urandom_range(0, 5) : $urandom_range(0, 30);
      end
    end
  end

  // Monitor: compare each output beat against the oldest prediction.
  mapped_t want;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_maps.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected beat: value %0d empty %0b",
                                      out_value_o, range_empty_o);
      end else begin
        want = expected_maps.pop_front();
        if (out_value_o !== want.value || range_empty_o !== want.empty) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: value exp %0d got %0d, empty exp %0b got %0b",
                     want.value, out_value_o, want.empty, range_empty_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("tb_clamped_range_map_with_easing_top failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[DW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegInStart:  range_in_lo = longint'($signed(val[DW-1:0]));
      RegInEnd:    range_in_hi = longint'($signed(val[DW-1:0]));
      RegOutStart: range_out_lo = longint'($signed(val[DW-1:0]));
      default:     range_out_hi = longint'($signed(val[DW-1:0]));
    endcase
  endtask

  task automatic set_ranges(longint a, longint b, longint c, longint d);
    write_reg(RegInStart, a);
    write_reg(RegInEnd, b);
    write_reg(RegOutStart, c);
    write_reg(RegOutEnd, d);
  endtask

  // Run a batch and wait until all its beats have come out.
  task automatic run_batch();
    feed_on = 1'b1;
    while (pending_samples.size() > 0 || expected_maps.size() > 0) @(posedge clk_i);
    feed_on = 1'b0;
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [DW-1:0] pick_value();
    longint span, v;
    span = range_in_hi - range_in_lo;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return range_in_lo[DW-1:0];
      2: return range_in_hi[DW-1:0];
      3: return {1'b1, {(DW-1){1'b0}}};
      4: return {1'b0, {(DW-1){1'b1}}};
      default: begin
        // mostly inside the input range, a little past either end
        v = range_in_lo + (span * longint'($urandom_range(0, 1200))) / 1000 - span / 10;
        return v[DW-1:0];
      end
    endcase
  endfunction

  task automatic add_random(int n);
    sample_t s;
    repeat (n) begin
      s.value = pick_value();
      s.mode = ease_e'($urandom_range(0, 3));
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    longint r0, r1, r2, r3;
    range_in_lo = 0;
    range_in_hi = 9999;
    range_out_lo = 0;
    range_out_hi = 9999;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset ranges, every mode, ends and outside values.
    for (int m = 0; m < 4; m++) begin
      s.mode = ease_e'(m);
      s.value = -1;          pending_samples.push_back(s);
      s.value = 0;           pending_samples.push_back(s);
      s.value = 5000;        pending_samples.push_back(s);
      s.value = 9999;        pending_samples.push_back(s);
      s.value = 20000;       pending_samples.push_back(s);
    end
    s.mode = EaseLinear;
    s.value = {1'b1, {(DW-1){1'b0}}}; pending_samples.push_back(s);
    s.value = {1'b0, {(DW-1){1'b1}}}; pending_samples.push_back(s);
    run_batch();

    // Extremes: full-width ranges, reversed both sides, empty range.
    set_ranges(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648);
    add_random(40);
    run_batch();
    set_ranges(64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647);
    add_random(40);
    run_batch();
    set_ranges(123, 123, -77, 5000);
    add_random(10);
    run_batch();

    // Random settings.
    for (int ph = 0; ph < 12; ph++) begin
      r0 = $signed($urandom());
      r1 = ($urandom_range(0, 7) == 0) ? r0 : $signed($urandom());
      if ($urandom_range(0, 1)) r1 = r0 + $signed($urandom_range(0, 2000)) - 1000;
      r2 = $signed($urandom());
      r3 = $signed($urandom());
      set_ranges(r0, r1, r2, r3);
      add_random(60);
      run_batch();
    end

    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("tb_clamped_range_map_with_easing_top passed");
    end else begin
      $display("tb_clamped_range_map_with_easing_top failed");
    end
    $finish;
  end
endmodule
